@@ rtl/esc_pkg.sv @@
// ============================================================================
// esc_pkg
// Shared types, constants and tables for the epoch seconds to calendar block.
// ============================================================================
package esc_pkg;

    localparam logic [11:0] FirstYear    = 12'd1970;
    localparam logic [10:0] BlockDays    = 11'd1461;
    localparam logic [8:0]  CommonDays   = 9'd365;
    localparam logic [8:0]  LeapDays     = 9'd366;
    localparam logic [10:0] LeapDayIndex = 11'd59;
    localparam logic [10:0] LeapDayStart = 11'd60;
    localparam logic [3:0]  LastMonthIdx = 4'd11;
    localparam logic [3:0]  February     = 4'd2;
    localparam logic [4:0]  LeapDayDate  = 5'd29;
    localparam logic [31:0] FirstWeekday = 32'd4;

    typedef enum logic [2:0] {
        DS_SEC,
        DS_MIN,
        DS_HOUR,
        DS_BLOCK,
        DS_WDAY
    } div_step_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_QD,
        F_FIX,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_YEAR,
        B_MONTH
    } back_state_t;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [5:0]  blocks;
        logic [10:0] block_day;
    } esc_entry_t;

    // Reciprocal floor(2^32 / divisor) for each division step.
    function automatic logic [31:0] div_mult(input div_step_t step);
        logic [31:0] m;
        case (step)
            DS_SEC:   m = 32'd71582788;
            DS_MIN:   m = 32'd71582788;
            DS_HOUR:  m = 32'd178956970;
            DS_BLOCK: m = 32'd2939744;
            DS_WDAY:  m = 32'd613566756;
            default:  m = 32'd0;
        endcase
        return m;
    endfunction

    function automatic logic [10:0] div_divisor(input div_step_t step);
        logic [10:0] d;
        case (step)
            DS_SEC:   d = 11'd60;
            DS_MIN:   d = 11'd60;
            DS_HOUR:  d = 11'd24;
            DS_BLOCK: d = BlockDays;
            DS_WDAY:  d = 11'd7;
            default:  d = 11'd1;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ rtl/esc_front.sv @@
// ============================================================================
// esc_front
// Accepts a timestamp and splits it with one shared constant divider into
// time of day, weekday, four-year block count and day within the block.
// ============================================================================
module esc_front import esc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] epoch_seconds,
    output logic        push,
    input  logic        queue_full,
    output esc_entry_t  entry
);

    front_state_t state_reg, state_next;
    div_step_t    step_reg;
    logic [31:0]  x_reg;
    logic [63:0]  prod_reg;
    logic [31:0]  q0_reg;
    logic [31:0]  qd_reg;
    logic [15:0]  days_reg;
    esc_entry_t   entry_reg;

    logic [10:0]  divisor;
    logic [31:0]  rem0;
    logic         fix;
    logic [31:0]  quot;
    logic [10:0]  rem;

    assign divisor = div_divisor(step_reg);
    assign rem0    = x_reg - qd_reg;
    assign fix     = rem0 >= {21'd0, divisor};
    assign quot    = fix ? q0_reg + 32'd1 : q0_reg;
    assign rem     = fix ? 11'(rem0 - {21'd0, divisor}) : rem0[10:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:   state_next = F_QD;
            F_QD:    state_next = F_FIX;
            F_FIX:   state_next = (step_reg == DS_WDAY) ? F_PUSH : F_MUL;
            F_PUSH:
            begin
                if (!queue_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        push     = 1'b0;
        case (state_reg)
            F_IDLE:  in_stall = 1'b0;
            F_PUSH:  push = !queue_full;
            default:
            begin
                in_stall = 1'b1;
                push     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                x_reg    <= epoch_seconds;
                step_reg <= DS_SEC;
            end
            F_MUL:
            begin
                prod_reg <= 64'(x_reg) * 64'(div_mult(step_reg));
            end
            F_QD:
            begin
                q0_reg <= prod_reg[63:32];
                qd_reg <= 32'(prod_reg[63:32] * {21'd0, divisor});
            end
            F_FIX:
            begin
                x_reg <= (step_reg == DS_BLOCK) ? {16'd0, days_reg} + FirstWeekday : quot;
                case (step_reg)
                    DS_SEC:
                    begin
                        entry_reg.second <= rem[5:0];
                        step_reg         <= DS_MIN;
                    end
                    DS_MIN:
                    begin
                        entry_reg.minute <= rem[5:0];
                        step_reg         <= DS_HOUR;
                    end
                    DS_HOUR:
                    begin
                        entry_reg.hour <= rem[4:0];
                        days_reg       <= quot[15:0];
                        step_reg       <= DS_BLOCK;
                    end
                    DS_BLOCK:
                    begin
                        entry_reg.blocks    <= quot[5:0];
                        entry_reg.block_day <= rem;
                        step_reg            <= DS_WDAY;
                    end
                    DS_WDAY:
                    begin
                        entry_reg.weekday <= rem[2:0];
                    end
                    default:
                    begin
                        step_reg <= DS_SEC;
                    end
                endcase
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign entry = entry_reg;

endmodule

@@ rtl/esc_queue.sv @@
// ============================================================================
// esc_queue
// Small first-in first-out queue between the front and the back.
// ============================================================================
module esc_queue import esc_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  esc_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output esc_entry_t pop_entry
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    esc_entry_t      mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full      = count_reg == FullCnt;
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/esc_back.sv @@
// ============================================================================
// esc_back
// Walks the years of a four-year block and the months of the year, one step
// per cycle, and holds the finished date in the output register.
// ============================================================================
module esc_back import esc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        entry_valid,
    input  esc_entry_t  entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  weekday
);

    back_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic [11:0] year_reg;
    logic [10:0] day_reg;
    logic [3:0]  mon_reg;
    logic        leap29_reg;
    esc_entry_t  hold_reg;

    logic [11:0] year_out_reg;
    logic [3:0]  month_out_reg;
    logic [4:0]  day_out_reg;
    logic [4:0]  hour_out_reg;
    logic [5:0]  minute_out_reg;
    logic [5:0]  second_out_reg;
    logic [2:0]  weekday_out_reg;

    logic        leap;
    logic [8:0]  year_len;
    logic        year_found;
    logic [4:0]  cur_len;
    logic        month_step;
    logic        slot_free;
    logic        finish;

    assign leap       = year_reg[1:0] == 2'b00;
    assign year_len   = leap ? LeapDays : CommonDays;
    assign year_found = day_reg < {2'b00, year_len};
    assign cur_len    = month_len(mon_reg);
    assign month_step = !leap29_reg && (mon_reg < LastMonthIdx)
                        && ({6'd0, cur_len} < day_reg);
    assign slot_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (entry_valid)
                begin
                    state_next = B_YEAR;
                end
            end
            B_YEAR:
            begin
                if (year_found)
                begin
                    state_next = B_MONTH;
                end
            end
            B_MONTH:
            begin
                if (!month_step && slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop    = 1'b0;
        finish = 1'b0;
        case (state_reg)
            B_IDLE:  pop = entry_valid;
            B_MONTH: finish = !month_step && slot_free;
            default:
            begin
                pop    = 1'b0;
                finish = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                hold_reg <= entry;
                year_reg <= FirstYear + {4'd0, entry.blocks, 2'b00};
                day_reg  <= entry.block_day;
            end
            B_YEAR:
            begin
                if (year_found)
                begin
                    leap29_reg <= leap && (day_reg == LeapDayIndex);
                    day_reg    <= (leap && (day_reg >= LeapDayStart)) ? day_reg
                                                                      : day_reg + 11'd1;
                    mon_reg    <= '0;
                end
                else
                begin
                    day_reg  <= day_reg - {2'b00, year_len};
                    year_reg <= year_reg + 12'd1;
                end
            end
            B_MONTH:
            begin
                if (month_step)
                begin
                    day_reg <= day_reg - {6'd0, cur_len};
                    mon_reg <= mon_reg + 4'd1;
                end
            end
            default:
            begin
                day_reg <= day_reg;
            end
        endcase

        if (finish)
        begin
            year_out_reg    <= year_reg;
            month_out_reg   <= leap29_reg ? February : mon_reg + 4'd1;
            day_out_reg     <= leap29_reg ? LeapDayDate : day_reg[4:0];
            hour_out_reg    <= hold_reg.hour;
            minute_out_reg  <= hold_reg.minute;
            second_out_reg  <= hold_reg.second;
            weekday_out_reg <= hold_reg.weekday;
        end
    end

    assign out_valid    = out_valid_reg;
    assign year         = year_out_reg;
    assign month        = month_out_reg;
    assign day_of_month = day_out_reg;
    assign hour         = hour_out_reg;
    assign minute       = minute_out_reg;
    assign second       = second_out_reg;
    assign weekday      = weekday_out_reg;

endmodule

@@ rtl/epoch_seconds_to_calendar.sv @@
// ============================================================================
// epoch_seconds_to_calendar
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 into
// year, month, day of month, hour, minute, second and weekday.
// ============================================================================
// The front runs five constant divisions (by 60, 60, 24, 1461 and 7)
// through one shared reciprocal-multiply divider, each in a multiply, a
// quotient and a correction state, and takes a new transaction only
// when it is idle again. The back walks at most four years and twelve
// months, one step per cycle, and the queue between the two lets either
// side stall without holding up the other until the queue runs full or empty.
// Every year that is divisible by four is taken as a leap year, 2100
// included.
module epoch_seconds_to_calendar import esc_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  weekday
);

    logic       push;
    logic       queue_full;
    logic       pop;
    logic       queue_valid;
    esc_entry_t front_entry;
    esc_entry_t back_entry;

    esc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .epoch_seconds (epoch_seconds),
        .push          (push),
        .queue_full    (queue_full),
        .entry         (front_entry)
    );

    esc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_valid),
        .pop_entry  (back_entry)
    );

    esc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (queue_valid),
        .entry        (back_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month),
        .hour         (hour),
        .minute       (minute),
        .second       (second),
        .weekday      (weekday)
    );

endmodule

@@ rtl/esc_checker.sv @@
// ============================================================================
// esc_checker
// Port-level checks on the results of the epoch seconds to calendar block.
// ============================================================================
module esc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [31:0] epoch_seconds,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day_of_month,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [2:0]  weekday
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(epoch_seconds))
        else $error("Stalled input transaction changed.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(year) && $stable(month)
            && $stable(day_of_month) && $stable(hour) && $stable(minute)
            && $stable(second) && $stable(weekday))
        else $error("Stalled result changed.");

    a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
            && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6)
        else $error("Result field out of range.");

    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> year >= 12'd1970 && year <= 12'd2106)
        else $error("Year out of range.");

    a_leap_day: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && month == 4'd2 |-> day_of_month < 5'd29
            || (day_of_month == 5'd29 && year[1:0] == 2'b00))
        else $error("Invalid February date.");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);
